>>> design/mma_pkg.sv
// mma_pkg: shared types, constants and the microcode ROM of the
// Moebius / Mertens accumulator. No dependencies.
`timescale 1ns / 1ps

package mma_pkg;

  // Default operand width
  localparam int N_BITS_DEF = 32;

  // Moebius value codes, 2-bit two's complement
  localparam logic [1:0] MOB_ZERO = 2'b00;
  localparam logic [1:0] MOB_POS  = 2'b01;
  localparam logic [1:0] MOB_NEG  = 2'b11;

  localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

  typedef logic [4:0] pc_t;

  typedef enum logic [3:0] {
    OP_IDLE,    // wait for an item, load operand
    OP_TEST,    // no datapath action, branch only
    OP_DIV,     // run the divider on t / f
    OP_HALVE,   // strip a factor 2, set f = 3
    OP_TAKE3,   // strip a factor 3 if it divides, set f = 5
    OP_TAKE,    // t = quotient, flip parity
    OP_ADV,     // next wheel candidate
    OP_END,     // leftover prime factor
    OP_ZERO,    // mark not squarefree
    OP_COMMIT   // update sum and tally, load result
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_T_LOW2_ZERO,
    C_REM_ZERO,
    C_REM_NZ,
    C_F_GT_Q
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Program labels
  localparam pc_t L_IDLE   = 5'd0;
  localparam pc_t L_LOOP   = 5'd7;
  localparam pc_t L_ADV    = 5'd13;
  localparam pc_t L_END    = 5'd14;
  localparam pc_t L_ZERO   = 5'd15;
  localparam pc_t L_COMMIT = 5'd16;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = '{OP_IDLE,   C_NEVER,       L_IDLE};
      5'd1:  w = '{OP_TEST,   C_T_LOW2_ZERO, L_ZERO};   // divisible by 4
      5'd2:  w = '{OP_DIV,    C_NEVER,       L_IDLE};   // t / 9
      5'd3:  w = '{OP_TEST,   C_REM_ZERO,    L_ZERO};   // divisible by 9
      5'd4:  w = '{OP_HALVE,  C_NEVER,       L_IDLE};
      5'd5:  w = '{OP_DIV,    C_NEVER,       L_IDLE};   // t / 3
      5'd6:  w = '{OP_TAKE3,  C_NEVER,       L_IDLE};
      5'd7:  w = '{OP_DIV,    C_NEVER,       L_IDLE};   // wheel: t / f
      5'd8:  w = '{OP_TEST,   C_F_GT_Q,      L_END};    // f*f > t
      5'd9:  w = '{OP_TEST,   C_REM_NZ,      L_ADV};
      5'd10: w = '{OP_TAKE,   C_NEVER,       L_IDLE};
      5'd11: w = '{OP_DIV,    C_NEVER,       L_IDLE};   // repeated factor?
      5'd12: w = '{OP_TEST,   C_REM_ZERO,    L_ZERO};
      5'd13: w = '{OP_ADV,    C_ALWAYS,      L_LOOP};
      5'd14: w = '{OP_END,    C_ALWAYS,      L_COMMIT};
      5'd15: w = '{OP_ZERO,   C_NEVER,       L_IDLE};
      5'd16: w = '{OP_COMMIT, C_ALWAYS,      L_IDLE};
      default: w = '{OP_TEST, C_ALWAYS,      L_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/mobius_mertens_accumulator_unit.sv
// Top level of the Moebius / Mertens accumulator: microcoded sequencer,
// trial-division datapath with a bit-serial divider. Uses mma_pkg.
`timescale 1ns / 1ps

// One item carries a positive integer; its low N_BITS bits are classified by
// trial division (2, 3, then a 6k+-1 wheel from 5) and the Moebius value
// (-1, 0, +1) is added to a 32-bit signed running sum that wraps. A
// saturating 32-bit counter tracks how many items left the sum at zero. Each
// result carries the Moebius value, the sum, a zero flag and the count.
// One item is processed at a time; in_ready is high only while the sequencer
// sits in its idle step. Cost is set by the shared restoring divider, whose
// divisions each run a load, N_BITS shift steps and a finish: an item pays
// for the 9 and 3 tests, plus a division per wheel candidate tried (up to
// sqrt of the remaining cofactor), plus more for each distinct prime found
// (take the factor, divide again for a square). Multiples of 4 finish with
// no division; a 32-bit prime near 2^32 needs about 21850 candidates.
// A finished result sits in the output register while the next item is
// accepted and worked on; only the commit step waits for a free slot.

module mobius_mertens_accumulator_unit #(
  parameter int N_BITS = mma_pkg::N_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_n,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mobius_value,
  output logic [31:0] out_running_sum,
  output logic        out_sum_is_zero,
  output logic [31:0] out_zero_hits
);

  localparam int CNT_W = $clog2(N_BITS + 1);

  // Sequencer
  mma_pkg::pc_t    pc_r, pc_nxt;
  mma_pkg::uword_t uw;
  logic            step_done;
  logic            cond_true;
  logic            in_fire;

  // Datapath registers
  logic [N_BITS-1:0] t_r, t_nxt;      // remaining cofactor
  logic [N_BITS-1:0] f_r, f_nxt;      // current trial divisor
  logic              odd_r, odd_nxt;  // parity of distinct primes
  logic              zf_r, zf_nxt;    // repeated factor found
  logic              step4_r, step4_nxt;

  // Divider
  logic              div_busy_r, div_busy_nxt;
  logic [CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [N_BITS-1:0] div_quo_r, div_quo_nxt;
  logic [N_BITS-1:0] div_rem_r, div_rem_nxt;
  logic [N_BITS:0]   rem_shift;
  logic [N_BITS:0]   rem_diff;
  logic              div_last;

  // Accumulator and result
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] tally_r, tally_nxt;
  logic [1:0]  code;
  logic        commit_fire;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_mob_r;
  logic [31:0] out_sum_r;
  logic        out_zero_r;
  logic [31:0] out_hits_r;

  logic [N_BITS-1:0] operand;

  assign operand  = N_BITS'(in_value_n);
  assign uw       = mma_pkg::ucode_rom(pc_r);
  assign in_ready = (uw.op == mma_pkg::OP_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign div_last = div_busy_r && (div_cnt_r == '0);
  assign commit_fire = (uw.op == mma_pkg::OP_COMMIT) && (!out_valid_r || out_ready);

  assign out_valid        = out_valid_r;
  assign out_mobius_value = out_mob_r;
  assign out_running_sum  = out_sum_r;
  assign out_sum_is_zero  = out_zero_r;
  assign out_zero_hits    = out_hits_r;

  // ---------------------------------------------------------------------
  // Next step: stay until the step finishes, then branch or fall through
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (uw.op)
      mma_pkg::OP_IDLE:   step_done = in_fire;
      mma_pkg::OP_DIV:    step_done = div_last;
      mma_pkg::OP_COMMIT: step_done = commit_fire;
      default:            step_done = 1'b1;
    endcase

    unique case (uw.cond)
      mma_pkg::C_NEVER:       cond_true = 1'b0;
      mma_pkg::C_ALWAYS:      cond_true = 1'b1;
      mma_pkg::C_T_LOW2_ZERO: cond_true = (t_r[1:0] == 2'b00);
      mma_pkg::C_REM_ZERO:    cond_true = (div_rem_r == '0);
      mma_pkg::C_REM_NZ:      cond_true = (div_rem_r != '0);
      mma_pkg::C_F_GT_Q:      cond_true = (f_r > div_quo_r);
      default:                cond_true = 1'b0;
    endcase

    pc_nxt = pc_r;
    if (step_done) begin
      pc_nxt = cond_true ? uw.target : pc_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath actions per control word
  // ---------------------------------------------------------------------
  always_comb begin
    rem_shift = {div_rem_r, div_quo_r[N_BITS-1]};
    rem_diff  = rem_shift - {1'b0, f_r};

    t_nxt        = t_r;
    f_nxt        = f_r;
    odd_nxt      = odd_r;
    zf_nxt       = zf_r;
    step4_nxt    = step4_r;
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_quo_nxt  = div_quo_r;
    div_rem_nxt  = div_rem_r;

    unique case (uw.op)
      mma_pkg::OP_IDLE: begin
        if (in_fire) begin
          t_nxt     = operand;
          f_nxt     = N_BITS'(9);
          odd_nxt   = 1'b0;
          zf_nxt    = 1'b0;
          step4_nxt = 1'b0;
        end
      end
      mma_pkg::OP_DIV: begin
        if (!div_busy_r) begin
          div_busy_nxt = 1'b1;
          div_cnt_nxt  = CNT_W'(N_BITS);
          div_quo_nxt  = t_r;
          div_rem_nxt  = '0;
        end else if (div_last) begin
          div_busy_nxt = 1'b0;
        end else begin
          // one restoring step per cycle
          div_cnt_nxt = div_cnt_r - 1'b1;
          if (!rem_diff[N_BITS]) begin
            div_rem_nxt = rem_diff[N_BITS-1:0];
            div_quo_nxt = {div_quo_r[N_BITS-2:0], 1'b1};
          end else begin
            div_rem_nxt = rem_shift[N_BITS-1:0];
            div_quo_nxt = {div_quo_r[N_BITS-2:0], 1'b0};
          end
        end
      end
      mma_pkg::OP_HALVE: begin
        if (!t_r[0]) begin
          t_nxt   = t_r >> 1;
          odd_nxt = !odd_r;
        end
        f_nxt = N_BITS'(3);
      end
      mma_pkg::OP_TAKE3: begin
        if (div_rem_r == '0) begin
          t_nxt   = div_quo_r;
          odd_nxt = !odd_r;
        end
        f_nxt = N_BITS'(5);
      end
      mma_pkg::OP_TAKE: begin
        t_nxt   = div_quo_r;
        odd_nxt = !odd_r;
      end
      mma_pkg::OP_ADV: begin
        // wheel: +2, +4, +2, ...
        f_nxt     = f_r + (step4_r ? N_BITS'(4) : N_BITS'(2));
        step4_nxt = !step4_r;
      end
      mma_pkg::OP_END: begin
        if (t_r != N_BITS'(1)) odd_nxt = !odd_r;
      end
      mma_pkg::OP_ZERO: begin
        zf_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sum, tally and result slot
  // ---------------------------------------------------------------------
  always_comb begin
    if (zf_r)       code = mma_pkg::MOB_ZERO;
    else if (odd_r) code = mma_pkg::MOB_NEG;
    else            code = mma_pkg::MOB_POS;

    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    if (commit_fire) begin
      if (code == mma_pkg::MOB_POS)      sum_nxt = sum_r + 32'd1;
      else if (code == mma_pkg::MOB_NEG) sum_nxt = sum_r - 32'd1;
      if (sum_nxt == 32'd0 && tally_r != mma_pkg::TALLY_MAX) begin
        tally_nxt = tally_r + 32'd1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (commit_fire)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mma_pkg::L_IDLE;
      div_busy_r  <= 1'b0;
      sum_r       <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      div_busy_r  <= div_busy_nxt;
      sum_r       <= sum_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    f_r       <= f_nxt;
    odd_r     <= odd_nxt;
    zf_r      <= zf_nxt;
    step4_r   <= step4_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_quo_r <= div_quo_nxt;
    div_rem_r <= div_rem_nxt;
    if (commit_fire) begin
      out_mob_r  <= code;
      out_sum_r  <= sum_nxt;
      out_zero_r <= (sum_nxt == 32'd0);
      out_hits_r <= tally_nxt;
    end
  end

`ifndef SYNTHESIS
  // no item taken while a division is in flight
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy_r)
    else $error("item accepted while divider busy");

  // divider finishes the cycle after its count runs out
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    div_last |=> !div_busy_r)
    else $error("divider did not stop");

  // each commit moves the sum by at most one
  a_sum_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire |=> (sum_r == $past(sum_r)) || (sum_r == $past(sum_r) + 32'd1)
                    || (sum_r == $past(sum_r) - 32'd1))
    else $error("running sum jumped");

  // tally only counts up
  a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> tally_r >= $past(tally_r))
    else $error("zero tally decreased");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for mobius_mertens_accumulator_unit: drives integers
// over the valid/ready input, predicts each Moebius value, sum and zero count,
// and checks every result in order. Depends on mma_pkg and the design top.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 100000; // cycles with no item moving on either side
  localparam int HOLD_CYCLES    = 3000;   // long receiver hold-off for the backpressure test
  localparam int DRAIN_CYCLES   = 200;    // quiet time after the last expected result

  typedef struct {
    logic [31:0] value;
    logic [1:0]  mobius;
    logic [31:0] sum;
    logic        is_zero;
    logic [31:0] hits;
  } mertens_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value_n = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_mobius_value;
  logic [31:0] out_running_sum;
  logic        out_sum_is_zero;
  logic [31:0] out_zero_hits;

  // predictor state
  logic signed [31:0] mertens_sum = '0;
  logic [31:0]        zero_count = '0;
  mertens_result_t    pending_results[$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned zero_results = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_req = 1'b0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_hold_left = 0;

  mobius_mertens_accumulator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value_n       (in_value_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mobius_value (out_mobius_value),
    .out_running_sum  (out_running_sum),
    .out_sum_is_zero  (out_sum_is_zero),
    .out_zero_hits    (out_zero_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trial division: 2 and 3 first, then the 6k+-1 wheel from 5.
  function automatic logic [1:0] mobius_code_of(input logic [31:0] n);
    longint unsigned t;
    longint unsigned f;
    longint unsigned step;
    bit odd;
    t = n;
    f = 5;
    step = 2;
    odd = 1'b0;
    if (t % 4 == 0 || t % 9 == 0) return mma_pkg::MOB_ZERO;
    if (t % 2 == 0) begin
      t = t / 2;
      odd = !odd;
    end
    if (t % 3 == 0) begin
      t = t / 3;
      odd = !odd;
    end
    while (f <= t / f) begin
      if (t % f == 0) begin
        t = t / f;
        odd = !odd;
        if (t % f == 0) return mma_pkg::MOB_ZERO;
      end
      f = f + step;
      step = 6 - step;
    end
    if (t != 1) odd = !odd;
    return odd ? mma_pkg::MOB_NEG : mma_pkg::MOB_POS;
  endfunction

  // Called once per accepted item, in acceptance order.
  task automatic record_accept(input logic [31:0] v);
    mertens_result_t r;
    r.value  = v;
    r.mobius = mobius_code_of(v);
    if (r.mobius == mma_pkg::MOB_POS) mertens_sum = mertens_sum + 32'sd1;
    else if (r.mobius == mma_pkg::MOB_NEG) mertens_sum = mertens_sum - 32'sd1;
    if (mertens_sum == 0 && zero_count != mma_pkg::TALLY_MAX) zero_count = zero_count + 1;
    r.sum     = mertens_sum;
    r.is_zero = (mertens_sum == 0);
    r.hits    = zero_count;
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Offer one item, optionally after a random sender gap; returns once accepted.
  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_value_n <= v;
    do @(posedge clk); while (!in_ready);
    record_accept(v);
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    mertens_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_sum_is_zero) zero_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, mobius=%0d sum=%0d", $time,
                 out_mobius_value, $signed(out_running_sum));
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_mobius_value !== want.mobius) begin
          $display("%0t: n=%0d mobius_value expected %0d actual %0d", $time,
                   want.value, want.mobius, out_mobius_value);
          mismatches++;
        end
        if (out_running_sum !== want.sum) begin
          $display("%0t: n=%0d running_sum expected %0d actual %0d", $time,
                   want.value, $signed(want.sum), $signed(out_running_sum));
          mismatches++;
        end
        if (out_sum_is_zero !== want.is_zero) begin
          $display("%0t: n=%0d sum_is_zero expected %0d actual %0d", $time,
                   want.value, want.is_zero, out_sum_is_zero);
          mismatches++;
        end
        if (out_zero_hits !== want.hits) begin
          $display("%0t: n=%0d zero_hits expected %0d actual %0d", $time,
                   want.value, want.hits, out_zero_hits);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no item moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Fed 1, 2, 3, ... from reset the sum walks the Mertens function, which
  // returns to zero at 2, 39, 40 and so on.
  task automatic test_mertens_sequence();
    for (int unsigned k = 1; k <= 40; k++) send_value(k);
  endtask

  task automatic test_directed_values();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd25,
             32'd49, 32'd35, 32'd30, 32'd30030, 32'd65521, 32'd1000003,
             32'd35632835,          // 5*7*1009*1009: square found deep in the wheel
             32'hFFFF_FFFF,         // 3*5*17*257*65537
             32'h8000_0000, 32'hFFFF_FFFC,
             32'hAAAA_AAAA, 32'h5555_5555, 32'd18};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Pick small values whose Moebius value pulls the sum back toward zero.
  function automatic logic [31:0] zero_seeking_value();
    logic [31:0] cand;
    logic [1:0]  code;
    cand = 1;
    for (int i = 0; i < 8; i++) begin
      cand = $urandom_range(1, 4000);
      code = mobius_code_of(cand);
      if (mertens_sum > 0 && code == mma_pkg::MOB_NEG) break;
      if (mertens_sum < 0 && code == mma_pkg::MOB_POS) break;
      if (mertens_sum == 0) break;
    end
    return cand;
  endfunction

  // Product of random factors below 512: wide operands, short wheel runs.
  function automatic logic [31:0] smooth_value();
    longint unsigned prod;
    longint unsigned k;
    prod = 1;
    repeat (12) begin
      k = $urandom_range(2, 511);
      if (prod * k <= 64'hFFFF_FFFF) prod = prod * k;
    end
    return prod[31:0];
  endfunction

  task automatic test_random_values(input int unsigned count);
    logic [31:0] v;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = zero_seeking_value();
        3, 4:    v = $urandom_range(1, 65535);
        5:       v = {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b00};
        6:       v = 9 * $urandom_range(0, 477218588);
        default: v = smooth_value();
      endcase
      send_value(v);
    end
  endtask

  // Receiver holds off while the sender keeps offering items back to back.
  task automatic test_output_backpressure();
    bit saved_tx;
    saved_tx = tx_idle_en;
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (8) send_value($urandom_range(1, 2000));
    tx_idle_en = saved_tx;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_mertens_sequence();

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_directed_values();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_values(15);
    test_output_backpressure();
    test_random_values(10);

    // last stretch runs with no idling at all
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_values(5);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: a Mertens walk from 1, edge values, wheel squares,",
             items_sent);
    $display("random and smooth operands under stalls; %0d results checked, %0d at zero sum",
             results_seen, zero_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> mobius_mertens_accumulator_unit.f
design/mma_pkg.sv
design/mobius_mertens_accumulator_unit.sv
tb/testbench.sv
